>>> rtl/trcd_pkg.sv
package trcd_pkg;

	localparam int MAX_POINTS_DEF = 5;
	localparam int COORD_BITS_DEF = 11;
	localparam int POINT_FIELDS   = 5;
	localparam int NUM_REGS       = 7;
	localparam int REG_IDX_W      = 3;
	localparam int REG_W          = 32;
	localparam int POS_W          = 16;
	localparam int RAW_W          = 16;

	// register indexes on the configuration port
	localparam logic [REG_IDX_W-1:0] REG_XX       = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_XY       = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_X_OFFSET = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_YX       = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_YY       = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_Y_OFFSET = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_DIVISOR  = 3'd6;

	localparam logic signed [REG_W-1:0] CAL_UNITY = 32'sd65536;

	// event codes
	localparam logic [1:0] EV_POINT   = 2'd0;
	localparam logic [1:0] EV_FRAME   = 2'd1;
	localparam logic [1:0] EV_RELEASE = 2'd2;

	typedef struct packed {
		logic [2:0]       touch_count;
		logic [RAW_W-1:0] raw_x0;
		logic [RAW_W-1:0] raw_y0;
		logic [RAW_W-1:0] raw_x1;
		logic [RAW_W-1:0] raw_y1;
		logic [RAW_W-1:0] raw_x2;
		logic [RAW_W-1:0] raw_y2;
		logic [RAW_W-1:0] raw_x3;
		logic [RAW_W-1:0] raw_y3;
		logic [RAW_W-1:0] raw_x4;
		logic [RAW_W-1:0] raw_y4;
	} report_t;

	typedef struct packed {
		logic [1:0]       event_kind;
		logic [POS_W-1:0] pos_x;
		logic [POS_W-1:0] pos_y;
		logic             last_of_report;
		logic             bad_count;
	} event_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_START,
		ST_MUL,
		ST_ACC,
		ST_CHK,
		ST_DIV,
		ST_CMP,
		ST_EMIT,
		ST_FRAME,
		ST_REL
	} state_t;

endpackage

>>> rtl/touch_report_calibrate_dedup.sv
// Channel | Handshake           | Word     | Contents
// --------+---------------------+----------+------------------------------------------
// in      | in_valid / in_stall | report_t | point count and five raw x/y words
// out     | out_valid/out_stall | event_t  | point, frame-end or release event
// cfg     | cfg_we              | 32 bits  | calibration register cfg_index
//
// One multiplier (32 x COORD_BITS+1) and one 33-bit subtractor are reused for every point.
// A calibrated point runs start, then per coordinate multiply/accumulate steps for the x,
// y and offset terms, a range check and a restoring division (skipped if the check clamps),
// then compare and emit, with no emit for a repeat of the last point; a zero divisor skips to compare.
// Reset loads the default calibration and marks the touch as released.
// Input is taken only in idle; a stalled output word holds and stalls the next word only.
module touch_report_calibrate_dedup #(
	parameter int MAX_POINTS = trcd_pkg::MAX_POINTS_DEF,
	parameter int COORD_BITS = trcd_pkg::COORD_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  trcd_pkg::report_t                    in_data,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output trcd_pkg::event_t                     out_data,
	input  logic                                 cfg_we,
	input  logic [trcd_pkg::REG_IDX_W-1:0]       cfg_index,
	input  logic [trcd_pkg::REG_W-1:0]           cfg_data
);
	import trcd_pkg::*;

	localparam int PROD_W  = REG_W + COORD_BITS + 1;
	localparam int ACC_W   = PROD_W + 2;
	localparam int QUOT_W  = POS_W;
	localparam int CMP_W   = (ACC_W > REG_W + QUOT_W) ? ACC_W : REG_W + QUOT_W;
	localparam int PI_W    = $clog2(POINT_FIELDS);
	localparam int BIT_W   = $clog2(QUOT_W);
	localparam logic [1:0] TERM_LAST = 2'd2;

	state_t state_q, state_d;

	logic signed [REG_W-1:0] cal_q [NUM_REGS];
	logic                    last_valid_q;
	logic [POS_W-1:0]        last_x_q, last_y_q;
	logic                    out_valid_q;
	event_t                  out_q;

	logic [COORD_BITS-1:0]   pt_x_q [POINT_FIELDS];
	logic [COORD_BITS-1:0]   pt_y_q [POINT_FIELDS];
	logic [2:0]              count_q;
	logic                    bad_q;
	logic [PI_W-1:0]         pi_q;
	logic                    coord_q;
	logic [1:0]              term_q;
	logic [BIT_W-1:0]        bit_q;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [ACC_W-1:0] acc_q;
	logic [REG_W-1:0]        dmag_q;
	logic                    dneg_q;
	logic [REG_W-1:0]        rem_q;
	logic [QUOT_W-1:0]       low_q;
	logic [POS_W-1:0]        cx_q, cy_q;

	// input decode
	logic [RAW_W-1:0]        raw_x [POINT_FIELDS];
	logic [RAW_W-1:0]        raw_y [POINT_FIELDS];
	logic                    in_bad, in_zero, in_take;

	always_comb begin
		raw_x[0] = in_data.raw_x0;
		raw_y[0] = in_data.raw_y0;
		raw_x[1] = in_data.raw_x1;
		raw_y[1] = in_data.raw_y1;
		raw_x[2] = in_data.raw_x2;
		raw_y[2] = in_data.raw_y2;
		raw_x[3] = in_data.raw_x3;
		raw_y[3] = in_data.raw_y3;
		raw_x[4] = in_data.raw_x4;
		raw_y[4] = in_data.raw_y4;
		in_bad   = (int'(in_data.touch_count) > MAX_POINTS) ||
		           (int'(in_data.touch_count) > POINT_FIELDS);
		in_zero  = in_bad || (in_data.touch_count == 3'd0);
	end

	assign in_take = in_valid && !in_stall;

	// shared multiplier operands
	logic signed [REG_W-1:0]  coef_sel;
	logic [COORD_BITS-1:0]    opnd_sel;
	logic signed [PROD_W-1:0] prod;

	always_comb begin
		case ({coord_q, term_q})
			3'b000:  coef_sel = cal_q[REG_XX];
			3'b001:  coef_sel = cal_q[REG_XY];
			3'b010:  coef_sel = cal_q[REG_X_OFFSET];
			3'b100:  coef_sel = cal_q[REG_YX];
			3'b101:  coef_sel = cal_q[REG_YY];
			3'b110:  coef_sel = cal_q[REG_Y_OFFSET];
			default: coef_sel = '0;
		endcase
		case (term_q)
			2'd0:    opnd_sel = pt_x_q[pi_q];
			2'd1:    opnd_sel = pt_y_q[pi_q];
			default: opnd_sel = COORD_BITS'(1);
		endcase
		prod = PROD_W'(coef_sel) * PROD_W'($signed({1'b0, opnd_sel}));
	end

	// range check and divider step
	logic              sum_neg, q_neg, q_sat;
	logic [ACC_W-1:0]  mag;
	logic [REG_W:0]    div_t, div_diff;
	logic              div_ge;
	logic              coord_wr;
	logic [POS_W-1:0]  coord_res;

	always_comb begin
		sum_neg  = acc_q[ACC_W-1];
		mag      = sum_neg ? ACC_W'(-acc_q) : ACC_W'(acc_q);
		q_neg    = sum_neg ^ dneg_q;
		q_sat    = CMP_W'(mag) >= CMP_W'({dmag_q, {QUOT_W{1'b0}}});
		div_t    = {rem_q, low_q[QUOT_W-1]};
		div_diff = div_t - {1'b0, dmag_q};
		div_ge   = div_t >= {1'b0, dmag_q};
		coord_wr  = 1'b0;
		coord_res = '0;
		if (state_q == ST_CHK && (q_neg || q_sat)) begin
			coord_wr  = 1'b1;
			coord_res = q_neg ? '0 : '1;
		end else if (state_q == ST_DIV && bit_q == BIT_W'(QUOT_W - 1)) begin
			coord_wr  = 1'b1;
			coord_res = {low_q[QUOT_W-2:0], div_ge};
		end
	end

	logic div_zero, last_pt, dup, out_free;

	assign div_zero = (cal_q[REG_DIVISOR] == '0);
	assign last_pt  = (pi_q == PI_W'(count_q - 3'd1));
	assign dup      = last_valid_q && (cx_q == last_x_q) && (cy_q == last_y_q);
	assign out_free = !out_valid_q || !out_stall;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_take) begin
					if (in_zero) state_d = last_valid_q ? ST_REL : ST_IDLE;
					else         state_d = ST_START;
				end
			end
			ST_START: state_d = div_zero ? ST_CMP : ST_MUL;
			ST_MUL:   state_d = ST_ACC;
			ST_ACC:   state_d = (term_q == TERM_LAST) ? ST_CHK : ST_MUL;
			ST_CHK: begin
				if (!coord_wr)     state_d = ST_DIV;
				else if (coord_q)  state_d = ST_CMP;
				else               state_d = ST_MUL;
			end
			ST_DIV: begin
				if (coord_wr) state_d = coord_q ? ST_CMP : ST_MUL;
			end
			ST_CMP: begin
				if (dup) state_d = last_pt ? ST_FRAME : ST_START;
				else     state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (out_free) state_d = last_pt ? ST_FRAME : ST_START;
			end
			ST_FRAME: if (out_free) state_d = ST_IDLE;
			ST_REL:   if (out_free) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	logic   out_load;
	event_t out_d;

	always_comb begin
		in_stall = (state_q != ST_IDLE);
		out_load = 1'b0;
		out_d    = '0;
		out_d.bad_count = bad_q;
		case (state_q)
			ST_EMIT: begin
				out_load         = out_free;
				out_d.event_kind = EV_POINT;
				out_d.pos_x      = cx_q;
				out_d.pos_y      = cy_q;
			end
			ST_FRAME: begin
				out_load             = out_free;
				out_d.event_kind     = EV_FRAME;
				out_d.last_of_report = 1'b1;
			end
			ST_REL: begin
				out_load             = out_free;
				out_d.event_kind     = EV_RELEASE;
				out_d.last_of_report = 1'b1;
			end
			default: out_load = 1'b0;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q                <= ST_IDLE;
			cal_q[REG_XX]          <= CAL_UNITY;
			cal_q[REG_XY]          <= '0;
			cal_q[REG_X_OFFSET]    <= '0;
			cal_q[REG_YX]          <= '0;
			cal_q[REG_YY]          <= CAL_UNITY;
			cal_q[REG_Y_OFFSET]    <= '0;
			cal_q[REG_DIVISOR]     <= CAL_UNITY;
			last_valid_q           <= 1'b0;
			last_x_q               <= '0;
			last_y_q               <= '0;
			out_valid_q            <= 1'b0;
		end else begin
			state_q <= state_d;
			// drop writes beyond the register list
			if (cfg_we && int'(cfg_index) < NUM_REGS) begin
				cal_q[cfg_index] <= $signed(cfg_data);
			end
			if (state_q == ST_EMIT && out_load) begin
				last_valid_q <= 1'b1;
				last_x_q     <= cx_q;
				last_y_q     <= cy_q;
			end
			if (state_q == ST_REL && out_load) begin
				last_valid_q <= 1'b0;
			end
			if (out_load)             out_valid_q <= 1'b1;
			else if (!out_stall)      out_valid_q <= 1'b0;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (out_load) out_q <= out_d;
		case (state_q)
			ST_IDLE: begin
				if (in_take) begin
					for (int i = 0; i < POINT_FIELDS; i++) begin
						pt_x_q[i] <= raw_x[i][COORD_BITS-1:0];
						pt_y_q[i] <= raw_y[i][COORD_BITS-1:0];
					end
					count_q <= in_data.touch_count;
					bad_q   <= in_bad;
					pi_q    <= '0;
				end
			end
			ST_START: begin
				coord_q <= 1'b0;
				term_q  <= '0;
				acc_q   <= '0;
				dneg_q  <= cal_q[REG_DIVISOR][REG_W-1];
				dmag_q  <= cal_q[REG_DIVISOR][REG_W-1] ? REG_W'(-cal_q[REG_DIVISOR])
				                                       : REG_W'(cal_q[REG_DIVISOR]);
				if (div_zero) begin
					cx_q <= POS_W'(pt_x_q[pi_q]);
					cy_q <= POS_W'(pt_y_q[pi_q]);
				end
			end
			ST_MUL: prod_q <= prod;
			ST_ACC: begin
				acc_q <= acc_q + ACC_W'(prod_q);
				if (term_q != TERM_LAST) term_q <= term_q + 2'd1;
			end
			ST_CHK: begin
				rem_q <= REG_W'(mag >> QUOT_W);
				low_q <= mag[QUOT_W-1:0];
				bit_q <= '0;
			end
			ST_DIV: begin
				// shift quotient bits in where dividend bits leave
				rem_q <= div_ge ? div_diff[REG_W-1:0] : div_t[REG_W-1:0];
				low_q <= {low_q[QUOT_W-2:0], div_ge};
				bit_q <= bit_q + BIT_W'(1);
			end
			ST_CMP: begin
				if (dup && !last_pt) pi_q <= pi_q + PI_W'(1);
			end
			ST_EMIT: begin
				if (out_free && !last_pt) pi_q <= pi_q + PI_W'(1);
			end
			default: begin
			end
		endcase
		if (coord_wr) begin
			if (coord_q) cy_q <= coord_res;
			else         cx_q <= coord_res;
			// advance to the second coordinate
			coord_q <= 1'b1;
			term_q  <= '0;
			acc_q   <= '0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

`ifndef SYNTHESIS
	a_div_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (rem_q < dmag_q))
		else $error("divider remainder not below divisor");

	a_point_tracks_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.event_kind == EV_POINT) |->
		(last_valid_q && last_x_q == out_q.pos_x && last_y_q == out_q.pos_y))
		else $error("pending point word differs from tracked last point");

	a_release_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_REL && out_free) |=> (!last_valid_q && out_valid_q))
		else $error("release did not clear touch state");
`endif

endmodule
